// ===== rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg - shared types and constants for the point rotation core
// Coordinate formats, pipeline beat structs and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int COORD_W       = 24;
    localparam int ANG_W         = 17;
    localparam int ANG_X_W       = 18;  // angle with one extra bit for folding
    localparam int DIFF_W        = 25;  // point - center
    localparam int GAIN_W        = 31;
    localparam int PROD_W        = DIFF_W + GAIN_W;
    localparam int GUARD_BITS    = 16;
    localparam int GAIN_SHIFT    = 30 - GUARD_BITS;
    localparam int CW            = 44;  // CORDIC datapath width
    localparam int Z_W           = 32;  // angle accumulator, 2^-23 degree units
    localparam int ANG_EXTRA     = 16;
    localparam int RND_W         = CW - GUARD_BITS;
    localparam int SUM_W         = RND_W + 1;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_ITER      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // angle constants in 1/128 degree
    localparam logic signed [ANG_X_W-1:0] ANG_FULL    = 18'sd46080;
    localparam logic signed [ANG_X_W-1:0] ANG_HALF    = 18'sd23040;
    localparam logic signed [ANG_X_W-1:0] ANG_QUARTER = 18'sd11520;

    // converged CORDIC gain, Q30
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
    localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [CW-1:0]     OUT_RND  = CW'(1) <<< (GUARD_BITS - 1);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [ANG_W-1:0]  ang;
        t_coord                   cx;
        t_coord                   cy;
    } t_wrap_beat;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [Z_W-1:0]    z;
        t_coord                   cx;
        t_coord                   cy;
    } t_off_beat;

    typedef struct packed {
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
        logic signed [Z_W-1:0]    z;
        t_coord                   cx;
        t_coord                   cy;
    } t_prod_beat;

    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [Z_W-1:0] z;
        t_coord                cx;
        t_coord                cy;
    } t_rot_beat;

    typedef struct packed {
        logic signed [RND_W-1:0] qx;
        logic signed [RND_W-1:0] qy;
        t_coord                  cx;
        t_coord                  cy;
    } t_post_beat;

    // atan(2^-i) in 2^-23 degree units
    function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd377487360;
            1:       v = 32'sd222843801;
            2:       v = 32'sd117744544;
            3:       v = 32'sd59768969;
            4:       v = 32'sd30000467;
            5:       v = 32'sd15014858;
            6:       v = 32'sd7509261;
            7:       v = 32'sd3754860;
            8:       v = 32'sd1877459;
            9:       v = 32'sd938733;
            10:      v = 32'sd469367;
            11:      v = 32'sd234683;
            12:      v = 32'sd117342;
            13:      v = 32'sd58671;
            14:      v = 32'sd29335;
            15:      v = 32'sd14668;
            16:      v = 32'sd7334;
            17:      v = 32'sd3667;
            18:      v = 32'sd1833;
            19:      v = 32'sd917;
            20:      v = 32'sd458;
            21:      v = 32'sd229;
            22:      v = 32'sd115;
            23:      v = 32'sd57;
            default: v = '0;
        endcase
        return v;
    endfunction

    // saturate a sum to the coordinate range
    function automatic t_coord sat_coord(input logic signed [SUM_W-1:0] s);
        t_coord v;
        if (s[SUM_W-1:COORD_W-1] == '0 || s[SUM_W-1:COORD_W-1] == '1) begin
            v = s[COORD_W-1:0];
        end else if (s[SUM_W-1]) begin
            v = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            v = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return v;
    endfunction

endpackage

// ===== rtl/prc_prep.sv =====
// ----------------------------------------------------------------------------
// prc_prep - offset and angle range reduction
// Stage 1 forms point - center and wraps the angle into (-180, 180] degrees.
// Stage 2 folds the angle into [-90, 90] degrees, negating the offset when it folds.
// ----------------------------------------------------------------------------
module prc_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  prc_pkg::t_coord    i_point_x,
    input  prc_pkg::t_coord    i_point_y,
    input  prc_pkg::t_coord    i_center_x,
    input  prc_pkg::t_coord    i_center_y,
    input  logic signed [prc_pkg::ANG_W-1:0] i_angle_deg,
    output logic               o_valid,
    input  logic               i_ready,
    output prc_pkg::t_off_beat o_data
);

    logic                                 r_v0, r_v1;
    prc_pkg::t_wrap_beat                  r_d0, n_d0;
    prc_pkg::t_off_beat                   r_d1, n_d1;
    logic                                 w_rdy0, w_rdy1;
    logic signed [prc_pkg::ANG_X_W-1:0]   w_a, w_r;

    assign w_rdy1  = !r_v1 || i_ready;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;
    assign o_valid = r_v1;
    assign o_data  = r_d1;

    always_comb begin
        w_a = {i_angle_deg[prc_pkg::ANG_W-1], i_angle_deg};
        if (w_a > prc_pkg::ANG_HALF) begin
            w_a = w_a - prc_pkg::ANG_FULL;
        end else if (w_a <= -prc_pkg::ANG_HALF) begin
            w_a = w_a + prc_pkg::ANG_FULL;
        end
        n_d0.dx  = {i_point_x[prc_pkg::COORD_W-1], i_point_x}
                 - {i_center_x[prc_pkg::COORD_W-1], i_center_x};
        n_d0.dy  = {i_point_y[prc_pkg::COORD_W-1], i_point_y}
                 - {i_center_y[prc_pkg::COORD_W-1], i_center_y};
        n_d0.ang = w_a[prc_pkg::ANG_W-1:0];
        n_d0.cx  = i_center_x;
        n_d0.cy  = i_center_y;
    end

    always_comb begin
        w_r     = {r_d0.ang[prc_pkg::ANG_W-1], r_d0.ang};
        n_d1.dx = r_d0.dx;
        n_d1.dy = r_d0.dy;
        if (w_r > prc_pkg::ANG_QUARTER) begin
            w_r     = w_r - prc_pkg::ANG_HALF;
            n_d1.dx = -r_d0.dx;
            n_d1.dy = -r_d0.dy;
        end else if (w_r < -prc_pkg::ANG_QUARTER) begin
            w_r     = w_r + prc_pkg::ANG_HALF;
            n_d1.dx = -r_d0.dx;
            n_d1.dy = -r_d0.dy;
        end
        // folded angle fits 16 bits; scale to 2^-23 degree units
        n_d1.z  = {w_r[15:0], {prc_pkg::ANG_EXTRA{1'b0}}};
        n_d1.cx = r_d0.cx;
        n_d1.cy = r_d0.cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_d0 <= n_d0;
        end
        if (w_rdy1 && r_v0) begin
            r_d1 <= n_d1;
        end
    end

endmodule

// ===== rtl/prc_gain.sv =====
// ----------------------------------------------------------------------------
// prc_gain - CORDIC gain compensation
// Stage 1 multiplies the offset by K in Q30, stage 2 rounds to guard bits.
// ----------------------------------------------------------------------------
module prc_gain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  prc_pkg::t_off_beat i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output prc_pkg::t_rot_beat o_data
);

    logic                                r_v0, r_v1;
    prc_pkg::t_prod_beat                 r_d0, n_d0;
    prc_pkg::t_rot_beat                  r_d1, n_d1;
    logic                                w_rdy0, w_rdy1;
    logic signed [prc_pkg::PROD_W-1:0]   w_tx, w_ty;

    assign w_rdy1  = !r_v1 || i_ready;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;
    assign o_valid = r_v1;
    assign o_data  = r_d1;

    always_comb begin
        n_d0.px = i_data.dx * prc_pkg::GAIN_Q30;
        n_d0.py = i_data.dy * prc_pkg::GAIN_Q30;
        n_d0.z  = i_data.z;
        n_d0.cx = i_data.cx;
        n_d0.cy = i_data.cy;
    end

    // round half up, keep GUARD_BITS fraction bits below the coordinate LSB
    always_comb begin
        w_tx    = r_d0.px + prc_pkg::GAIN_RND;
        w_ty    = r_d0.py + prc_pkg::GAIN_RND;
        n_d1.x  = prc_pkg::CW'(w_tx >>> prc_pkg::GAIN_SHIFT);
        n_d1.y  = prc_pkg::CW'(w_ty >>> prc_pkg::GAIN_SHIFT);
        n_d1.z  = r_d0.z;
        n_d1.cx = r_d0.cx;
        n_d1.cy = r_d0.cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_d0 <= n_d0;
        end
        if (w_rdy1 && r_v0) begin
            r_d1 <= n_d1;
        end
    end

endmodule

// ===== rtl/prc_cordic.sv =====
// ----------------------------------------------------------------------------
// prc_cordic - unrolled rotation-mode CORDIC
// One registered micro-rotation per stage, NUM_ITER stages.
// ----------------------------------------------------------------------------
module prc_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  prc_pkg::t_rot_beat i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output prc_pkg::t_rot_beat o_data
);

    localparam int N = prc_pkg::NUM_ITER;

    logic               r_v  [N];
    prc_pkg::t_rot_beat r_d  [N];
    prc_pkg::t_rot_beat n_d  [N];
    prc_pkg::t_rot_beat w_in [N];
    logic               w_vin[N];
    logic               w_rdy[N];

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[N-1];
    assign o_data  = r_d[N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [prc_pkg::CW-1:0] w_xs, w_ys;

        if (k == 0) begin : g_first
            assign w_in[k]  = i_data;
            assign w_vin[k] = i_valid;
        end else begin : g_next
            assign w_in[k]  = r_d[k-1];
            assign w_vin[k] = r_v[k-1];
        end

        if (k == N - 1) begin : g_last
            assign w_rdy[k] = !r_v[k] || i_ready;
        end else begin : g_mid
            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end

        assign w_xs = w_in[k].x >>> k;
        assign w_ys = w_in[k].y >>> k;

        always_comb begin
            n_d[k].cx = w_in[k].cx;
            n_d[k].cy = w_in[k].cy;
            if (!w_in[k].z[prc_pkg::Z_W-1]) begin
                n_d[k].x = w_in[k].x - w_ys;
                n_d[k].y = w_in[k].y + w_xs;
                n_d[k].z = w_in[k].z - prc_pkg::atan_lut(k);
            end else begin
                n_d[k].x = w_in[k].x + w_ys;
                n_d[k].y = w_in[k].y - w_xs;
                n_d[k].z = w_in[k].z + prc_pkg::atan_lut(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_vin[k]) begin
                r_d[k] <= n_d[k];
            end
        end
    end

endmodule

// ===== rtl/prc_post.sv =====
// ----------------------------------------------------------------------------
// prc_post - output rounding, center add-back and saturation
// Stage 1 drops the guard bits, stage 2 adds the center and clamps.
// ----------------------------------------------------------------------------
module prc_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  prc_pkg::t_rot_beat i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output prc_pkg::t_coord    o_rotated_x,
    output prc_pkg::t_coord    o_rotated_y
);

    logic                              r_v0, r_v1;
    prc_pkg::t_post_beat               r_d0, n_d0;
    prc_pkg::t_coord                   r_x, r_y, n_x, n_y;
    logic                              w_rdy0, w_rdy1;
    logic signed [prc_pkg::CW-1:0]     w_tx, w_ty;
    logic signed [prc_pkg::SUM_W-1:0]  w_sx, w_sy;

    assign w_rdy1      = !r_v1 || i_ready;
    assign w_rdy0      = !r_v0 || w_rdy1;
    assign o_ready     = w_rdy0;
    assign o_valid     = r_v1;
    assign o_rotated_x = r_x;
    assign o_rotated_y = r_y;

    always_comb begin
        w_tx    = i_data.x + prc_pkg::OUT_RND;
        w_ty    = i_data.y + prc_pkg::OUT_RND;
        n_d0.qx = w_tx[prc_pkg::CW-1:prc_pkg::GUARD_BITS];
        n_d0.qy = w_ty[prc_pkg::CW-1:prc_pkg::GUARD_BITS];
        n_d0.cx = i_data.cx;
        n_d0.cy = i_data.cy;
    end

    always_comb begin
        w_sx = {r_d0.qx[prc_pkg::RND_W-1], r_d0.qx}
             + prc_pkg::SUM_W'(r_d0.cx);
        w_sy = {r_d0.qy[prc_pkg::RND_W-1], r_d0.qy}
             + prc_pkg::SUM_W'(r_d0.cy);
        n_x  = prc_pkg::sat_coord(w_sx);
        n_y  = prc_pkg::sat_coord(w_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_d0 <= n_d0;
        end
        if (w_rdy1 && r_v0) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

endmodule

// ===== rtl/point_rotate_about_center_core.sv =====
// ----------------------------------------------------------------------------
// point_rotate_about_center_core - rotate a 2D point about a center
// Fixed-point rotation by a CORDIC with gain compensation and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes a point, a center (signed, 8
//   fraction bits) and an angle in 1/128 degree; any 17-bit angle is wrapped.
//   Output channel (o_valid / i_ready) gives the rotated point, saturated
//   to the 24-bit coordinate range. One result beat per input beat, in order.
//   The pipeline has 2 prep stages, 2 gain stages, one stage per
//   CORDIC iteration (16) and 2 output stages.
//   Throughput is one beat per cycle while i_ready is high (unrolled CORDIC).
//   Every stage carries its own valid bit and is loaded when empty or when
//   the next stage moves, so bubbles collapse and a new beat is taken while
//   a finished result waits on the output register.
//   When the receiver stalls, stages fill up from the output back; o_ready
//   drops only once the whole pipeline is full. Nothing is dropped or
//   repeated.
//   Reset (i_rst_n low, synchronous) clears all valid bits; no result is
//   presented until new beats arrive.
// ----------------------------------------------------------------------------
module point_rotate_about_center_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [prc_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [prc_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [prc_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [prc_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [prc_pkg::ANG_W-1:0]   i_angle_deg,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [prc_pkg::COORD_W-1:0] o_rotated_x,
    output logic signed [prc_pkg::COORD_W-1:0] o_rotated_y
);

    prc_pkg::t_off_beat w_off;
    prc_pkg::t_rot_beat w_gain, w_rot;
    logic               w_off_v, w_off_rdy;
    logic               w_gain_v, w_gain_rdy;
    logic               w_rot_v, w_rot_rdy;

    prc_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_angle_deg (i_angle_deg),
        .o_valid     (w_off_v),
        .i_ready     (w_off_rdy),
        .o_data      (w_off)
    );

    prc_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_off_v),
        .o_ready (w_off_rdy),
        .i_data  (w_off),
        .o_valid (w_gain_v),
        .i_ready (w_gain_rdy),
        .o_data  (w_gain)
    );

    prc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_gain_v),
        .o_ready (w_gain_rdy),
        .i_data  (w_gain),
        .o_valid (w_rot_v),
        .i_ready (w_rot_rdy),
        .o_data  (w_rot)
    );

    prc_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_rot_v),
        .o_ready     (w_rot_rdy),
        .i_data      (w_rot),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rotated_x (o_rotated_x),
        .o_rotated_y (o_rotated_y)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - point rotation about a center, randomized self-checking bench
// Drives point/center/angle beats through the valid/ready input, predicts
// each rotated point with a bit-exact fixed-point CORDIC of its own, and
// checks every output beat in order. Covers angle wrapping and folding,
// saturation, zero offset, random idling, long receiver stalls and drains.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic signed [prc_pkg::COORD_W-1:0] t_coord;

    typedef logic signed [prc_pkg::ANG_W-1:0] t_angle;

    typedef struct {
        t_coord x;
        t_coord y;
    } t_rot_point;

    localparam longint TURN_FULL    = 46080;
    localparam longint TURN_HALF    = 23040;
    localparam longint TURN_QUARTER = 11520;
    localparam longint GAIN_K_Q30   = 652032874;
    localparam int     ROT_STEPS    = 16;
    localparam int     GUARD        = 16;
    localparam longint COORD_HI     = 8388607;
    localparam longint COORD_LO     = -8388608;

    // atan(2^-i), 2^-23 degree units
    longint atan_z [24] = '{
        377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
        7509261, 3754860, 1877459, 938733, 469367, 234683,
        117342, 58671, 29335, 14668, 7334, 3667,
        1833, 917, 458, 229, 115, 57
    };

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_point_x;
    t_coord i_point_y;
    t_coord i_center_x;
    t_coord i_center_y;
    t_angle i_angle_deg;
    logic   o_valid;
    logic   i_ready;
    t_coord o_rotated_x;
    t_coord o_rotated_y;

    t_rot_point  pending_rot [$];
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int          rx_hold_cycles = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_sat = 0;
    int unsigned n_in_stall = 0;

    point_rotate_about_center_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_angle_deg (i_angle_deg),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rotated_x (o_rotated_x),
        .o_rotated_y (o_rotated_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout at %0t, %0d results still pending", $time, pending_rot.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor: fold angle, scale offset by CORDIC gain, rotate, round, add
    // center back and clamp
    // ------------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic t_rot_point rotate_about_center(input t_coord px, input t_coord py,
                                                      input t_coord cx, input t_coord cy,
                                                      input t_angle ang);
        longint     dx, dy, a, x, y, z, xs, ys;
        t_rot_point r;
        dx = longint'(px) - longint'(cx);
        dy = longint'(py) - longint'(cy);
        a  = longint'(ang) % TURN_FULL;
        if (a < 0) a += TURN_FULL;
        if (a > TURN_HALF) a -= TURN_FULL;
        // keep the CORDIC within +-90 degrees by turning the offset around
        if (a > TURN_QUARTER) begin
            a -= TURN_HALF;
            dx = -dx;
            dy = -dy;
        end else if (a < -TURN_QUARTER) begin
            a += TURN_HALF;
            dx = -dx;
            dy = -dy;
        end
        x = (dx * GAIN_K_Q30 + (longint'(1) <<< (29 - GUARD))) >>> (30 - GUARD);
        y = (dy * GAIN_K_Q30 + (longint'(1) <<< (29 - GUARD))) >>> (30 - GUARD);
        z = a * 65536;
        for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_z[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_z[i];
            end
        end
        x = (x + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
        y = (y + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
        x = clamp_coord(x + longint'(cx));
        y = clamp_coord(y + longint'(cy));
        r.x = t_coord'(x);
        r.y = t_coord'(y);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_point(input t_coord px, input t_coord py, input t_coord cx,
                              input t_coord cy, input t_angle ang);
        t_rot_point want;
        @(negedge i_clk);
        if (tx_idle_en) begin
            while ($urandom_range(99) < 25) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_point_x   <= px;
        i_point_y   <= py;
        i_center_x  <= cx;
        i_center_y  <= cy;
        i_angle_deg <= ang;
        want = rotate_about_center(px, py, cx, cy, ang);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_rot.insert(pending_rot.size(), want);
        n_sent++;
        if (want.x == t_coord'(COORD_HI) || want.x == t_coord'(COORD_LO)) n_sat++;
        if (want.y == t_coord'(COORD_HI) || want.y == t_coord'(COORD_LO)) n_sat++;
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(4))
            0, 1:    return t_coord'($urandom);
            2, 3:    return t_coord'(int'($urandom_range(131072)) - 65536);
            default: begin
                if ($urandom_range(1))
                    return t_coord'(COORD_HI - longint'($urandom_range(3)));
                return t_coord'(COORD_LO + longint'($urandom_range(3)));
            end
        endcase
    endfunction

    function automatic t_angle rand_angle();
        int base;
        case ($urandom_range(3))
            0: return t_angle'($urandom);
            1: return t_angle'(int'($urandom_range(92160)) - 46080);
            2: begin
                case ($urandom_range(6))
                    0:       base = 0;
                    1:       base = 11520;
                    2:       base = -11520;
                    3:       base = 23040;
                    4:       base = -23040;
                    5:       base = 46080;
                    default: base = -46080;
                endcase
                return t_angle'(base + int'($urandom_range(4)) - 2);
            end
            default: return t_angle'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    task automatic send_random_points(input int n);
        for (int k = 0; k < n; k++) begin
            send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_angle());
        end
    endtask

    task automatic wait_drained();
        while (pending_rot.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // output side: random ready, with an optional long hold-off
    // ------------------------------------------------------------------------
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                i_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(99) < 25) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_rot_point want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rot.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result beat x=%0d y=%0d",
                         $time, o_rotated_x, o_rotated_y);
            end else begin
                want = pending_rot.pop_front();
                n_checked++;
                if (o_rotated_x !== want.x) begin
                    n_errors++;
                    $display("%0t: rotated_x mismatch, expected %0d, got %0d",
                             $time, want.x, o_rotated_x);
                end
                if (o_rotated_y !== want.y) begin
                    n_errors++;
                    $display("%0t: rotated_y mismatch, expected %0d, got %0d",
                             $time, want.y, o_rotated_y);
                end
            end
        end
        if (i_rst_n && i_valid && !o_ready) n_in_stall++;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // identity, quarter, half and full turns, wrap of the whole angle field
        send_point(24'sd256, 24'sd0, 24'sd0, 24'sd0, 17'sd0);
        send_point(24'sd256, 24'sd0, 24'sd0, 24'sd0, 17'sd11520);
        send_point(24'sd256, 24'sd512, 24'sd0, 24'sd0, -17'sd11520);
        send_point(24'sd1000, -24'sd300, 24'sd50, 24'sd70, 17'sd23040);
        send_point(24'sd1000, -24'sd300, 24'sd50, 24'sd70, -17'sd23040);
        send_point(24'sd4096, 24'sd4096, -24'sd128, 24'sd128, 17'sd46080);
        send_point(24'sd4096, 24'sd4096, -24'sd128, 24'sd128, -17'sd46080);
        send_point(24'sd77777, -24'sd12345, 24'sd1, -24'sd1, 17'sd65535);
        send_point(24'sd77777, -24'sd12345, 24'sd1, -24'sd1, -17'sd65536);
        // just past the fold points
        send_point(24'sd30000, 24'sd20000, 24'sd0, 24'sd0, 17'sd11521);
        send_point(24'sd30000, 24'sd20000, 24'sd0, 24'sd0, -17'sd11521);
        send_point(24'sd30000, 24'sd20000, 24'sd0, 24'sd0, 17'sd23041);
        // zero offset gives back the center
        send_point(24'sd1234567, -24'sd7654321, 24'sd1234567, -24'sd7654321, 17'sd12345);
        // offsets at the field extremes, with and without saturation
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 17'sd23040);
        send_point(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 17'sd0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 24'sd0, 17'sd5760);
        send_point(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, -17'sd11520);
        send_point(24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 17'sd17);
        send_point(-24'sd1, -24'sd1, 24'sd0, 24'sd0, 17'sd1);
        send_point(24'sh800000, 24'sh800000, 24'sd0, 24'sd0, 17'sd11520);
    endtask

    task automatic test_random_idle(input int n);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_points(n);
    endtask

    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_points(150);
    endtask

    // receiver stops long enough for the pipeline to fill and drop o_ready
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        rx_hold_cycles = 80;
        send_random_points(60);
    endtask

    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_points(30);
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        send_random_points(30);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_point_x   = '0;
        i_point_y   = '0;
        i_center_x  = '0;
        i_center_y  = '0;
        i_angle_deg = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_idle(300);
        test_steady_stream();
        test_backpressure();
        test_drain_pause();
        test_random_idle(110);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("rotated %0d points, %0d results checked, %0d saturated coordinates",
                 n_sent, n_checked, n_sat);
        $display("angle wrap/fold edges, extremes, idle gaps; input stalled %0d cycles",
                 n_in_stall);
        if (n_errors == 0 && pending_rot.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
